// ===== src/pjs_pkg.sv =====
package pjs_pkg;

  localparam int unsigned TS_W             = 48;
  localparam int unsigned PER_W            = 24;
  localparam int unsigned MEAN_W           = 28;
  localparam int unsigned VAR_W            = 46;
  localparam int unsigned SD_W             = 28;
  localparam int unsigned SEEN_W           = 32;
  localparam int unsigned SQRT_IN_W        = 2 * SD_W;
  localparam int unsigned VCLAMP_W         = SQRT_IN_W - 8;
  localparam int unsigned WINDOW_DEPTH_DEF = 64;

  localparam logic [PER_W-1:0] TARGET_RST = 24'd100000;
  localparam logic [PER_W-1:0] THRESH_RST = 24'd5000;

  typedef enum logic [0:0] {
    REG_TARGET = 1'b0,
    REG_THRESH = 1'b1
  } pjs_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_SQ,
    ST_UPD,
    ST_MUL,
    ST_SUB,
    ST_DST,
    ST_DIV,
    ST_RST,
    ST_ROOT,
    ST_OUT
  } pjs_state_e;

  typedef struct packed {
    logic             has;
    logic [PER_W-1:0] period;
  } pjs_item_t;

  typedef struct packed {
    logic [PER_W-1:0] target;
    logic [PER_W-1:0] thresh;
  } pjs_cfg_t;

endpackage

// ===== src/period_jitter_statistics.sv =====
// channel  dir  handshake                      payload
// in       in   in_valid_i / in_ready_o        timestamp_us_i
// out      out  out_valid_o / out_ready_i      has_period_o .. jitter_alarm_o
// cfg      in   psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// The time a beat takes is set by the bit-serial variance divide followed by the
// 28-step square root; a beat without a period skips the ring states RD, SQ, UPD.
// A two-beat queue in front lets timestamps be taken while a result waits.
// Reset is asynchronous, active low; the ring needs no clearing pass.
// A stalled output holds the back end; the front keeps going until the queue fills.
module period_jitter_statistics #(
  parameter int unsigned WINDOW_DEPTH = pjs_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pjs_pkg::TS_W-1:0]          timestamp_us_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              has_period_o,
  output logic [pjs_pkg::PER_W-1:0]         period_o,
  output logic [pjs_pkg::PER_W-1:0]         period_lo_o,
  output logic [pjs_pkg::PER_W-1:0]         period_hi_o,
  output logic [pjs_pkg::PER_W-1:0]         dev_peak_o,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0] window_count_o,
  output logic [pjs_pkg::SEEN_W-1:0]        event_count_o,
  output logic [pjs_pkg::MEAN_W-1:0]        mean_q4_o,
  output logic [pjs_pkg::VAR_W-1:0]         variance_o,
  output logic [pjs_pkg::SD_W-1:0]          stddev_q4_o,
  output logic                              stats_valid_o,
  output logic                              jitter_alarm_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import pjs_pkg::*;

  pjs_cfg_t  cfg_q;
  pjs_reg_e  reg_sel;
  logic      q_valid, q_ready;
  pjs_item_t q_item;

  assign pready  = 1'b1;
  assign reg_sel = pjs_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target <= TARGET_RST;
      cfg_q.thresh <= THRESH_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_TARGET: cfg_q.target <= pwdata[PER_W-1:0];
        REG_THRESH: cfg_q.thresh <= pwdata[PER_W-1:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TARGET: prdata = {{(32-PER_W){1'b0}}, cfg_q.target};
      REG_THRESH: prdata = {{(32-PER_W){1'b0}}, cfg_q.thresh};
      default:    prdata = '0;
    endcase
  end

  pjs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .timestamp_us_i (timestamp_us_i),
    .q_valid_o      (q_valid),
    .q_ready_i      (q_ready),
    .q_item_o       (q_item)
  );

  pjs_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_ready_o       (q_ready),
    .q_item_i        (q_item),
    .cfg_i           (cfg_q),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .has_period_o    (has_period_o),
    .period_o        (period_o),
    .period_lo_o     (period_lo_o),
    .period_hi_o     (period_hi_o),
    .dev_peak_o      (dev_peak_o),
    .window_count_o  (window_count_o),
    .event_count_o   (event_count_o),
    .mean_q4_o       (mean_q4_o),
    .variance_o      (variance_o),
    .stddev_q4_o     (stddev_q4_o),
    .stats_valid_o   (stats_valid_o),
    .jitter_alarm_o  (jitter_alarm_o)
  );

endmodule

// ===== src/pjs_front.sv =====
module pjs_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [pjs_pkg::TS_W-1:0] timestamp_us_i,
  output logic                     q_valid_o,
  input  logic                     q_ready_i,
  output pjs_pkg::pjs_item_t       q_item_o
);
  import pjs_pkg::*;

  logic [TS_W-1:0] prev_q;
  logic            prev_vld_q;
  logic [TS_W:0]   diff;
  pjs_item_t       new_item;
  pjs_item_t       buf_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  assign diff = {1'b0, timestamp_us_i} - {1'b0, prev_q};

  always_comb begin
    new_item.has = prev_vld_q;
    if (!prev_vld_q || diff[TS_W]) begin
      new_item.period = '0;
    end else if (|diff[TS_W-1:PER_W]) begin
      new_item.period = '1;
    end else begin
      new_item.period = diff[PER_W-1:0];
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rp_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = q_valid_o & q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      prev_vld_q <= 1'b0;
      wp_q       <= 1'b0;
      rp_q       <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      if (push) begin
        prev_q     <= timestamp_us_i;
        prev_vld_q <= 1'b1;
        wp_q       <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= new_item;
    end
  end

endmodule

// ===== src/pjs_div.sv =====
module pjs_div #(
  parameter int unsigned NUM_W = 61,
  parameter int unsigned DEN_W = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  assign trial  = {rem_q, quo_q[NUM_W-1]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = (trial >= {1'b0, den_q});
  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(NUM_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_o) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== src/pjs_sqrt.sv =====
module pjs_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pjs_pkg::SQRT_IN_W-1:0] x_i,
  output logic                          busy_o,
  output logic [pjs_pkg::SD_W-1:0]      root_o
);
  import pjs_pkg::*;

  localparam int unsigned REM_W = SD_W + 4;

  logic [SQRT_IN_W-1:0] x_q;
  logic [SD_W-1:0]      root_q;
  logic [REM_W-3:0]     rem_q;
  logic [REM_W-1:0]     r2, trial, diff;
  logic                 ge;
  logic [4:0]           cnt_q;

  assign r2     = {rem_q, x_q[SQRT_IN_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign diff   = r2 - trial;
  assign ge     = (r2 >= trial);
  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 5'(SD_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  // one root digit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_o) begin
      x_q    <= {x_q[SQRT_IN_W-3:0], 2'b00};
      root_q <= {root_q[SD_W-2:0], ge};
      rem_q  <= ge ? diff[REM_W-3:0] : r2[REM_W-3:0];
    end
  end

endmodule

// ===== src/pjs_back.sv =====
module pjs_back #(
  parameter int unsigned WINDOW_DEPTH = pjs_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  output logic                                  q_ready_o,
  input  pjs_pkg::pjs_item_t                    q_item_i,
  input  pjs_pkg::pjs_cfg_t                     cfg_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  has_period_o,
  output logic [pjs_pkg::PER_W-1:0]             period_o,
  output logic [pjs_pkg::PER_W-1:0]             period_lo_o,
  output logic [pjs_pkg::PER_W-1:0]             period_hi_o,
  output logic [pjs_pkg::PER_W-1:0]             dev_peak_o,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0]     window_count_o,
  output logic [pjs_pkg::SEEN_W-1:0]            event_count_o,
  output logic [pjs_pkg::MEAN_W-1:0]            mean_q4_o,
  output logic [pjs_pkg::VAR_W-1:0]             variance_o,
  output logic [pjs_pkg::SD_W-1:0]              stddev_q4_o,
  output logic                                  stats_valid_o,
  output logic                                  jitter_alarm_o
);
  import pjs_pkg::*;

  localparam int unsigned AW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW  = PER_W + AW;
  localparam int unsigned QW  = 2 * PER_W + AW;
  localparam int unsigned NW  = QW + CW;
  localparam int unsigned DW  = 2 * CW;
  localparam int unsigned MNW = SW + 4;

  pjs_state_e state_q, state_d;

  logic [PER_W-1:0]   ring_mem [WINDOW_DEPTH];
  logic [PER_W-1:0]   rd_q;
  logic               ram_we;

  pjs_item_t          item_q;
  logic [AW-1:0]      ptr_q;
  logic [CW-1:0]      cnt_q;
  logic [SW-1:0]      sum_q;
  logic [QW-1:0]      sq_q;
  logic [PER_W-1:0]   min_q, max_q, dev_q;
  logic [SEEN_W-1:0]  seen_q;
  logic [2*PER_W-1:0] psq_q, oldsq_q;
  logic [NW-1:0]      a_q, b_q, diff_q;
  logic [DW-1:0]      den_q;

  logic               full, two_plus;
  logic [PER_W-1:0]   dev;
  logic               div_start, sq_start, mdiv_busy, vdiv_busy, sq_busy;
  logic [MNW-1:0]     mquo;
  logic [NW-1:0]      vquo;
  logic [VCLAMP_W-1:0] vclamp;
  logic [SD_W-1:0]    root;

  assign full     = (cnt_q == CW'(WINDOW_DEPTH));
  assign two_plus = (cnt_q >= CW'(2));
  assign dev      = (item_q.period >= cfg_i.target) ? item_q.period - cfg_i.target
                                                    : cfg_i.target - item_q.period;
  assign vclamp   = (|vquo[NW-1:VCLAMP_W]) ? '1 : vquo[VCLAMP_W-1:0];

  always_comb begin
    state_d     = state_q;
    q_ready_o   = 1'b0;
    ram_we      = 1'b0;
    div_start   = 1'b0;
    sq_start    = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          state_d = q_item_i.has ? ST_RD : ST_MUL;
        end
      end
      ST_RD:   state_d = ST_SQ;
      ST_SQ:   state_d = ST_UPD;
      ST_UPD: begin
        ram_we  = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_SUB;
      ST_SUB:  state_d = ST_DST;
      ST_DST: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!mdiv_busy && !vdiv_busy) begin
          state_d = ST_RST;
        end
      end
      ST_RST: begin
        sq_start = 1'b1;
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        if (!sq_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ring storage; the oldest entry sits at the write pointer once full
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ring_mem[ptr_q] <= item_q.period;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= ring_mem[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      min_q  <= '1;
      max_q  <= '0;
      dev_q  <= '0;
      seen_q <= '0;
    end else if (state_q == ST_UPD) begin
      sum_q  <= sum_q + SW'(item_q.period) - (full ? SW'(rd_q) : '0);
      sq_q   <= sq_q + QW'(psq_q) - (full ? QW'(oldsq_q) : '0);
      ptr_q  <= (ptr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + AW'(1);
      if (!full) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (item_q.period < min_q) begin
        min_q <= item_q.period;
      end
      if (item_q.period > max_q) begin
        max_q <= item_q.period;
      end
      if (dev > dev_q) begin
        dev_q <= dev;
      end
      seen_q <= seen_q + SEEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i) begin
      item_q <= q_item_i;
    end
    if (state_q == ST_RD) begin
      psq_q <= item_q.period * item_q.period;
    end
    if (state_q == ST_SQ) begin
      oldsq_q <= rd_q * rd_q;
    end
    if (state_q == ST_MUL) begin
      a_q   <= NW'(cnt_q) * NW'(sq_q);
      b_q   <= NW'(sum_q) * NW'(sum_q);
      den_q <= DW'(cnt_q) * DW'(cnt_q - CW'(1));
    end
    if (state_q == ST_SUB) begin
      diff_q <= (a_q >= b_q) ? a_q - b_q : '0;
    end
    if (state_q == ST_ROOT && !sq_busy) begin
      has_period_o    <= item_q.has;
      period_o        <= item_q.period;
      period_lo_o     <= min_q;
      period_hi_o     <= max_q;
      dev_peak_o      <= dev_q;
      window_count_o  <= cnt_q;
      event_count_o   <= seen_q;
      mean_q4_o       <= (|cnt_q) ? mquo[MEAN_W-1:0] : '0;
      variance_o      <= !two_plus ? '0 : ((|vquo[NW-1:VAR_W]) ? '1 : vquo[VAR_W-1:0]);
      stddev_q4_o     <= two_plus ? root : '0;
      stats_valid_o   <= two_plus;
      jitter_alarm_o  <= (dev_q > cfg_i.thresh);
    end
  end

  pjs_div #(.NUM_W(MNW), .DEN_W(CW)) u_mean_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({sum_q, 4'b0000}),
    .den_i   (cnt_q),
    .busy_o  (mdiv_busy),
    .quo_o   (mquo)
  );

  pjs_div #(.NUM_W(NW), .DEN_W(DW)) u_var_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (diff_q),
    .den_i   (den_q),
    .busy_o  (vdiv_busy),
    .quo_o   (vquo)
  );

  pjs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     ({vclamp, 8'h00}),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

endmodule

// ===== src/pjs_checker.sv =====
module pjs_checker #(
  parameter int unsigned WINDOW_DEPTH = pjs_pkg::WINDOW_DEPTH_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic                              has_period_i,
  input logic [pjs_pkg::PER_W-1:0]         period_i,
  input logic [pjs_pkg::PER_W-1:0]         period_lo_i,
  input logic [pjs_pkg::PER_W-1:0]         period_hi_i,
  input logic [$clog2(WINDOW_DEPTH+1)-1:0] window_count_i,
  input logic [pjs_pkg::MEAN_W-1:0]        mean_q4_i,
  input logic [pjs_pkg::VAR_W-1:0]         variance_i,
  input logic                              stats_valid_i
);
  import pjs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(variance_i) && $stable(mean_q4_i))
    else $error("result changed while stalled");

  a_stats_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stats_valid_i |-> window_count_i >= 2)
    else $error("stats valid with fewer than two periods");

  a_no_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_period_i |-> period_i == '0)
    else $error("period nonzero without a measured period");

  a_empty_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && window_count_i == '0 |-> mean_q4_i == '0 && !stats_valid_i)
    else $error("empty window reports statistics");

  a_lo_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && has_period_i |-> period_lo_i <= period_i && period_hi_i >= period_i)
    else $error("period outside lo/hi");

endmodule

bind period_jitter_statistics pjs_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_pjs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .has_period_i   (has_period_o),
  .period_i       (period_o),
  .period_lo_i    (period_lo_o),
  .period_hi_i    (period_hi_o),
  .window_count_i (window_count_o),
  .mean_q4_i      (mean_q4_o),
  .variance_i     (variance_o),
  .stats_valid_i  (stats_valid_o)
);

// ===== dv/period_jitter_statistics_tb.sv =====
`timescale 1ns / 1ps

module period_jitter_statistics_tb;
  import pjs_pkg::*;

  localparam int unsigned DEPTH = WINDOW_DEPTH_DEF;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [VAR_W-1:0] VAR_MAX = '1;
  localparam logic [63:0] VCLAMP = (64'd1 << 48) - 1;

  typedef struct packed {
    logic              has;
    logic [PER_W-1:0]  period;
    logic [PER_W-1:0]  min_p;
    logic [PER_W-1:0]  max_p;
    logic [PER_W-1:0]  max_dev;
    logic [CNT_W-1:0]  count;
    logic [SEEN_W-1:0] seen;
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  var_v;
    logic [SD_W-1:0]   sd;
    logic              sv;
    logic              warn;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  logic [TS_W-1:0] ts_d = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  logic has_period_o, stats_valid_o, jitter_alarm_o;
  logic [PER_W-1:0] period_o, period_lo_o, period_hi_o, dev_peak_o;
  logic [CNT_W-1:0] window_count_o;
  logic [SEEN_W-1:0] event_count_o;
  logic [MEAN_W-1:0] mean_q4_o;
  logic [VAR_W-1:0] variance_o;
  logic [SD_W-1:0] stddev_q4_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  period_jitter_statistics dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o, .timestamp_us_i(ts_d),
    .out_valid_o, .out_ready_i(out_ready),
    .has_period_o, .period_o, .period_lo_o, .period_hi_o, .dev_peak_o,
    .window_count_o, .event_count_o, .mean_q4_o, .variance_o, .stddev_q4_o,
    .stats_valid_o, .jitter_alarm_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  logic [PER_W-1:0] m_target = TARGET_RST, m_thresh = THRESH_RST;
  logic [PER_W-1:0] m_ring [DEPTH];
  int unsigned m_ptr = 0, m_count = 0;
  logic [63:0] m_sum = 0, m_sqsum = 0;
  logic [TS_W-1:0] m_prev = '0;
  logic m_prev_ok = 1'b0;
  logic [PER_W-1:0] m_min = '1, m_max = '0, m_dev = '0;
  logic [SEEN_W-1:0] m_seen = '0;

  logic [TS_W-1:0] ts_pending[$];
  stats_t stats_expected[$];
  int unsigned send_idle = 0, recv_idle = 0;
  int unsigned errors = 0, beats_in = 0, beats_out = 0;
  logic hold_req = 1'b0;

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic void predict_stats(logic [TS_W-1:0] now);
    stats_t r;
    logic [63:0] p, d, old, n;
    logic [127:0] a, b, diff, v;
    r = '0;
    if (m_prev_ok) begin
      p = (now >= m_prev) ? 64'(now - m_prev) : 64'd0;
      if (p > 64'hFFFFFF) p = 64'hFFFFFF;
      if (m_count >= DEPTH) begin
        old = 64'(m_ring[m_ptr]);
        m_sum -= old;
        m_sqsum -= old * old;
      end else begin
        m_count++;
      end
      m_ring[m_ptr] = p[PER_W-1:0];
      m_sum += p;
      m_sqsum += p * p;
      m_ptr = (m_ptr + 1) % DEPTH;
      if (p[PER_W-1:0] < m_min) m_min = p[PER_W-1:0];
      if (p[PER_W-1:0] > m_max) m_max = p[PER_W-1:0];
      d = (p >= 64'(m_target)) ? p - 64'(m_target) : 64'(m_target) - p;
      if (d[PER_W-1:0] > m_dev) m_dev = d[PER_W-1:0];
      m_seen++;
      r.has = 1'b1;
      r.period = p[PER_W-1:0];
    end
    m_prev = now;
    m_prev_ok = 1'b1;
    if (m_count >= 1) r.mean = MEAN_W'((m_sum << 4) / m_count);
    if (m_count >= 2) begin
      n = 64'(m_count);
      a = 128'(n) * 128'(m_sqsum);
      b = 128'(m_sum) * 128'(m_sum);
      diff = (a < b) ? 128'd0 : a - b;
      v = diff / 128'(n * (n - 1));
      r.var_v = (v > 128'(VAR_MAX)) ? VAR_MAX : v[VAR_W-1:0];
      if (v > 128'(VCLAMP)) v = 128'(VCLAMP);
      r.sd = SD_W'(isqrt(v[63:0] << 8));
      r.sv = 1'b1;
    end
    r.min_p = m_min;
    r.max_p = m_max;
    r.max_dev = m_dev;
    r.count = CNT_W'(m_count);
    r.seen = m_seen;
    r.warn = m_dev > m_thresh;
    stats_expected.push_back(r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        predict_stats(ts_d);
        beats_in++;
      end
      if (!in_valid || in_ready_o) begin
        if (ts_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1'b1;
          ts_d <= ts_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  logic hold_seen = 1'b0;
  int unsigned hold_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    stats_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        beats_out++;
        if (stats_expected.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = stats_expected.pop_front();
          check_field("has_period", 64'(e.has), 64'(has_period_o));
          check_field("period", 64'(e.period), 64'(period_o));
          check_field("period_lo", 64'(e.min_p), 64'(period_lo_o));
          check_field("period_hi", 64'(e.max_p), 64'(period_hi_o));
          check_field("dev_peak", 64'(e.max_dev), 64'(dev_peak_o));
          check_field("window_count", 64'(e.count), 64'(window_count_o));
          check_field("event_count", 64'(e.seen), 64'(event_count_o));
          check_field("mean_q4", 64'(e.mean), 64'(mean_q4_o));
          check_field("variance", 64'(e.var_v), 64'(variance_o));
          check_field("stddev_q4", 64'(e.sd), 64'(stddev_q4_o));
          check_field("stats_valid", 64'(e.sv), 64'(stats_valid_o));
          check_field("jitter_alarm", 64'(e.warn), 64'(jitter_alarm_o));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= 2000;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic cfg_write(pjs_reg_e idx, logic [PER_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * int'(idx));
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_TARGET) m_target = val;
    else m_thresh = val;
  endtask

  task automatic wait_drained();
    while (ts_pending.size() > 0 || in_valid || stats_expected.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  logic [TS_W-1:0] last_ts = '0;

  task automatic push_ts(logic [TS_W-1:0] t);
    ts_pending.push_back(t);
    last_ts = t;
  endtask

  // mostly regular periods around the target, with some broken timing mixed in
  task automatic fill_random(int unsigned cnt, int unsigned spread);
    int unsigned k, sel;
    logic [TS_W-1:0] step;
    for (k = 0; k < cnt; k++) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        push_ts(last_ts - TS_W'($urandom_range(100000)));
      end else if (sel < 7) begin
        push_ts(last_ts);
      end else if (sel < 11) begin
        step = TS_W'({$urandom, $urandom});
        push_ts(last_ts + step);
      end else if (sel < 13) begin
        push_ts(TS_W'({$urandom, $urandom}));
      end else begin
        step = TS_W'(m_target) + TS_W'($urandom_range(2 * spread)) - TS_W'(spread);
        push_ts(last_ts + step);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // first event at time zero, then even, equal, backwards and huge steps
    send_idle = 18;
    recv_idle = 56;
    push_ts('0);
    push_ts(48'd100000);
    push_ts(48'd200000);
    push_ts(48'd200000);
    push_ts(48'd150000);
    push_ts(48'd250000);
    push_ts(48'd250000 + 48'hFFFFFF);
    push_ts(48'd250000 + 48'h1000000 + 48'hFFFFFF);
    push_ts('1);
    push_ts('0);
    push_ts(48'h5555_5555_5555);
    push_ts(48'hAAAA_AAAA_AAAA);
    push_ts(48'hAAAA_AAAA_AAAA + 48'd1);
    push_ts(48'hAAAA_AAAA_AAAA + 48'd2);
    push_ts(48'hAAAA_AAAA_AAAA + 48'd95000);
    push_ts(48'hAAAA_AAAA_AAAA + 48'd200000);
    wait_drained();

    fill_random(300, 4000);
    wait_drained();

    cfg_write(REG_TARGET, '0);
    cfg_write(REG_THRESH, '0);
    fill_random(20, 50);
    hold_req = ~hold_req;
    fill_random(280, 50);
    wait_drained();

    send_idle = 56;
    recv_idle = 18;
    cfg_write(REG_TARGET, '1);
    cfg_write(REG_THRESH, '1);
    fill_random(300, 8000000);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    cfg_write(REG_TARGET, PER_W'($urandom));
    cfg_write(REG_THRESH, PER_W'($urandom));
    fill_random(300, 1 + $urandom_range(500000));
    wait_drained();

    cfg_write(REG_TARGET, 24'd1000);
    cfg_write(REG_THRESH, 24'd50);
    fill_random(380, 100);
    wait_drained();

    $display("Sent %0d timestamps and checked %0d result beats over six settings.",
             beats_in, beats_out);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", stats_expected.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/pjs_pkg.sv
src/pjs_front.sv
src/pjs_div.sv
src/pjs_sqrt.sv
src/pjs_back.sv
src/period_jitter_statistics.sv
src/pjs_checker.sv
dv/period_jitter_statistics_tb.sv
